// ===== src/minh_pkg.sv =====
`default_nettype none
package minh_pkg;

    localparam int SIGN_SIZE = 8;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 31;
    localparam int MOD_W     = VAL_W + 1;

    localparam logic [VAL_W-1:0] INT_MAX = {VAL_W{1'b1}};

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ELEMENT = 1'b1;

    // request to the serial modular multiply-add unit
    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] modulus;
        logic [VAL_W-1:0] mult;
        logic [VAL_W-1:0] add;
        logic [VAL_W-1:0] element;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] hash;
    } mm_rsp_t;

endpackage
`default_nettype wire

// ===== src/minh_ifs.sv =====
`default_nettype none
interface minh_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [2:0]  coeff_index;
    logic [30:0] coeff_mult;
    logic [30:0] coeff_add;
    logic [30:0] element;
    logic        last_element;

    modport source (output valid, cmd, coeff_index, coeff_mult, coeff_add, element,
                    last_element, input ready);
    modport sink (input valid, cmd, coeff_index, coeff_mult, coeff_add, element,
                  last_element, output ready);
endinterface

interface minh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  hash_index;
    logic [30:0] min_value;
    logic        last_of_signature;

    modport source (output valid, hash_index, min_value, last_of_signature, input ready);
    modport sink (input valid, hash_index, min_value, last_of_signature, output ready);
endinterface

interface minh_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] prime_modulus;

    modport source (output valid, prime_modulus, input ready);
    modport sink (input valid, prime_modulus, output ready);
endinterface
`default_nettype wire

// ===== src/minh_mulmod.sv =====
`default_nettype none
module minh_mulmod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  minh_pkg::mm_req_t    req,
    output minh_pkg::mm_rsp_t    rsp
);
    import minh_pkg::*;

    localparam int CNT_W = $clog2(VAL_W);

    typedef enum logic [3:0] {
        MM_IDLE   = 4'b0001,
        MM_REDUCE = 4'b0010,
        MM_HORNER = 4'b0100,
        MM_FINISH = 4'b1000
    } mm_state_t;

    mm_state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [MOD_W-1:0] p_reg, p_next;
    logic [VAL_W-1:0] a_sh_reg, a_sh_next;
    logic [VAL_W-1:0] b_sh_reg, b_sh_next;
    logic [VAL_W-1:0] x_sh_reg, x_sh_next;
    logic [VAL_W-1:0] a_red_reg, a_red_next;
    logic [VAL_W-1:0] b_red_reg, b_red_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] hash_reg, hash_next;

    logic [MOD_W-1:0] red_a, red_a_n, red_b, red_b_n;
    logic [MOD_W:0]   p_wide, hx, h1, h2, fs, fr;

    always_comb
    begin
        // residue doubling plus one input bit, at most one subtract
        red_a   = {a_red_reg, a_sh_reg[VAL_W-1]};
        red_a_n = (red_a >= p_reg) ? red_a - p_reg : red_a;
        red_b   = {b_red_reg, b_sh_reg[VAL_W-1]};
        red_b_n = (red_b >= p_reg) ? red_b - p_reg : red_b;

        // Horner step on x, MSB first: 2*acc + bit*a < 3p
        p_wide = {1'b0, p_reg};
        hx     = {1'b0, acc_reg, 1'b0}
                 + (x_sh_reg[VAL_W-1] ? {2'b00, a_red_reg} : {(MOD_W+1){1'b0}});
        h1     = (hx >= p_wide) ? hx - p_wide : hx;
        h2     = (h1 >= p_wide) ? h1 - p_wide : h1;

        fs = {2'b00, acc_reg} + {2'b00, b_red_reg};
        fr = (fs >= p_wide) ? fs - p_wide : fs;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        p_next     = p_reg;
        a_sh_next  = a_sh_reg;
        b_sh_next  = b_sh_reg;
        x_sh_next  = x_sh_reg;
        a_red_next = a_red_reg;
        b_red_next = b_red_reg;
        acc_next   = acc_reg;
        hash_next  = hash_reg;
        case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = req.modulus;
                    a_sh_next  = req.mult;
                    b_sh_next  = req.add;
                    x_sh_next  = req.element;
                    a_red_next = '0;
                    b_red_next = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = MM_REDUCE;
                end
            end
            MM_REDUCE:
            begin
                a_red_next = red_a_n[VAL_W-1:0];
                b_red_next = red_b_n[VAL_W-1:0];
                a_sh_next  = {a_sh_reg[VAL_W-2:0], 1'b0};
                b_sh_next  = {b_sh_reg[VAL_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VAL_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = MM_HORNER;
                end
            end
            MM_HORNER:
            begin
                acc_next  = h2[VAL_W-1:0];
                x_sh_next = {x_sh_reg[VAL_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VAL_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = MM_FINISH;
                end
            end
            MM_FINISH:
            begin
                hash_next  = fr[VAL_W-1:0];
                done_next  = 1'b1;
                state_next = MM_IDLE;
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        a_sh_reg  <= a_sh_next;
        b_sh_reg  <= b_sh_next;
        x_sh_reg  <= x_sh_next;
        a_red_reg <= a_red_next;
        b_red_reg <= b_red_next;
        acc_reg   <= acc_next;
        hash_reg  <= hash_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hash = hash_reg;

endmodule
`default_nettype wire

// ===== src/minhash_signature_top.sv =====
// Channel  Dir  Payload
// item     in   cmd, coeff_index, coeff_mult, coeff_add, element, last_element
// result   out  hash_index, min_value, last_of_signature
// cfg      in   prime_modulus (always ready)
//
// Load request: written to the coefficient tables. Element request: each hash runs on one
// bit-serial multiply-add-mod unit (start, reducing a and b, Horner steps over x, final
// add, done), one hash after another for all hashes; item.ready is low meanwhile.
// After the last element, 8 results leave one per cycle while result.ready.
// Reset sets the modulus to 2147483647 and all minima to 2147483647.
`default_nettype none
module minhash_signature_top (
    input wire logic clk,
    input wire logic rst_n,
    minh_in_if.sink  item,
    minh_out_if.source result,
    minh_cfg_if.sink cfg
);
    import minh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HASH = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             issue_reg, issue_next;
    logic             last_reg, last_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [VAL_W-1:0] p_reg;

    logic [VAL_W-1:0] mult_tab_reg [SIGN_SIZE];
    logic [VAL_W-1:0] add_tab_reg  [SIGN_SIZE];
    logic [VAL_W-1:0] min_reg      [SIGN_SIZE];

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [VAL_W-1:0] out_min_reg, out_min_next;
    logic             out_last_reg, out_last_next;

    logic             item_fire, load_fire, min_wr, min_clear;
    mm_req_t          mm_req;
    mm_rsp_t          mm_rsp;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign load_fire  = item_fire && (item.cmd == CMD_LOAD)
                        && (32'(item.coeff_index) < SIGN_SIZE);
    assign cfg.ready  = 1'b1;

    assign mm_req.start   = issue_reg;
    assign mm_req.modulus = (p_reg == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, p_reg};
    assign mm_req.mult    = mult_tab_reg[idx_reg];
    assign mm_req.add     = add_tab_reg[idx_reg];
    assign mm_req.element = x_reg;

    minh_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign min_wr = (state_reg == ST_HASH) && mm_rsp.done
                    && (mm_rsp.hash < min_reg[idx_reg]);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issue_next     = 1'b0;
        last_next      = last_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_idx_next   = out_idx_reg;
        out_min_next   = out_min_reg;
        out_last_next  = out_last_reg;
        min_clear      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.cmd == CMD_ELEMENT))
                begin
                    x_next     = item.element;
                    last_next  = item.last_element;
                    idx_next   = '0;
                    issue_next = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mm_rsp.done)
                begin
                    if (idx_reg == IDX_W'(SIGN_SIZE - 1))
                    begin
                        idx_next   = '0;
                        state_next = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        issue_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_min_next   = min_reg[idx_reg];
                    out_last_next  = (idx_reg == IDX_W'(SIGN_SIZE - 1));
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(SIGN_SIZE - 1))
                    begin
                        idx_next   = '0;
                        min_clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            p_reg         <= INT_MAX;
            for (int i = 0; i < SIGN_SIZE; i++)
            begin
                min_reg[i] <= INT_MAX;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                p_reg <= cfg.prime_modulus;
            end
            if (min_clear)
            begin
                for (int i = 0; i < SIGN_SIZE; i++)
                begin
                    min_reg[i] <= INT_MAX;
                end
            end
            else if (min_wr)
            begin
                min_reg[idx_reg] <= mm_rsp.hash;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        x_reg        <= x_next;
        out_idx_reg  <= out_idx_next;
        out_min_reg  <= out_min_next;
        out_last_reg <= out_last_next;
        if (load_fire)
        begin
            mult_tab_reg[item.coeff_index] <= item.coeff_mult;
            add_tab_reg[item.coeff_index]  <= item.coeff_add;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.hash_index        = out_idx_reg;
    assign result.min_value         = out_min_reg;
    assign result.last_of_signature = out_last_reg;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import minh_pkg::*;

    localparam int SETTLE_CYCLES = 800;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 4000;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] coeff_index;
        logic [VAL_W-1:0] coeff_mult;
        logic [VAL_W-1:0] coeff_add;
        logic [VAL_W-1:0] element;
        logic             last_element;
    } item_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] hash_index;
        logic [VAL_W-1:0] min_value;
        logic             last_of_signature;
    } sig_entry_t;

    class minhash_scoreboard;
        bit [VAL_W-1:0] modulus;
        bit [VAL_W-1:0] mult_tab [SIGN_SIZE];
        bit [VAL_W-1:0] add_tab [SIGN_SIZE];
        bit [VAL_W-1:0] minima [SIGN_SIZE];
        sig_entry_t     signature_q [$];
        int             errors;

        function new();
            modulus = INT_MAX;
            errors  = 0;
            for (int i = 0; i < SIGN_SIZE; i++)
            begin
                mult_tab[i] = '0;
                add_tab[i]  = '0;
                minima[i]   = INT_MAX;
            end
        endfunction

        function void set_modulus(bit [VAL_W-1:0] m);
            modulus = m;
        endfunction

        function int pending();
            return signature_q.size();
        endfunction

        // exact (a*x+b) mod p; p == 0 keeps the low 31 bits
        function bit [VAL_W-1:0] hash_of(bit [VAL_W-1:0] a, bit [VAL_W-1:0] b,
                                         bit [VAL_W-1:0] x);
            bit [62:0] sum;
            sum = 63'(a) * 63'(x) + 63'(b);
            if (modulus == 0)
                return sum[VAL_W-1:0];
            sum = sum % 63'(modulus);
            return sum[VAL_W-1:0];
        endfunction

        function void apply_request(item_req_t r);
            bit [VAL_W-1:0] h;
            sig_entry_t     e;
            if (r.cmd == CMD_LOAD)
            begin
                mult_tab[r.coeff_index] = r.coeff_mult;
                add_tab[r.coeff_index]  = r.coeff_add;
                return;
            end
            for (int i = 0; i < SIGN_SIZE; i++)
            begin
                h = hash_of(mult_tab[i], add_tab[i], r.element);
                if (h < minima[i])
                    minima[i] = h;
            end
            if (!r.last_element)
                return;
            for (int i = 0; i < SIGN_SIZE; i++)
            begin
                e.hash_index        = IDX_W'(i);
                e.min_value         = minima[i];
                e.last_of_signature = (i == SIGN_SIZE - 1);
                signature_q         = {signature_q, e};
                minima[i] = INT_MAX;
            end
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_entry(sig_entry_t got);
            sig_entry_t want;
            if (signature_q.size() == 0)
            begin
                $display("%0t unexpected entry: hash_index %0d min_value %0d last %0d",
                         $time, got.hash_index, got.min_value, got.last_of_signature);
                errors++;
                return;
            end
            want = signature_q.pop_front();
            if (got.hash_index != want.hash_index)
                report("hash_index", want.hash_index, got.hash_index);
            if (got.min_value != want.min_value)
                report("min_value", want.min_value, got.min_value);
            if (got.last_of_signature != want.last_of_signature)
                report("last_of_signature", want.last_of_signature, got.last_of_signature);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    minh_in_if  item_bus ();
    minh_out_if result_bus ();
    minh_cfg_if cfg_bus ();

    minhash_signature_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    minhash_scoreboard board;
    int requests_sent = 0;
    int burst_left    = 0;
    bit hold_done     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return INT_MAX;
            2: return VAL_W'($urandom_range(1, 255));
            3: return INT_MAX - VAL_W'($urandom_range(1, 255));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic item_req_t load_req(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] a,
                                           logic [VAL_W-1:0] b);
        item_req_t r;
        r.cmd          = CMD_LOAD;
        r.coeff_index  = idx;
        r.coeff_mult   = a;
        r.coeff_add    = b;
        r.element      = VAL_W'($urandom);
        r.last_element = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic item_req_t elem_req(logic [VAL_W-1:0] x, logic last);
        item_req_t r;
        r.cmd          = CMD_ELEMENT;
        r.coeff_index  = IDX_W'($urandom);
        r.coeff_mult   = VAL_W'($urandom);
        r.coeff_add    = VAL_W'($urandom);
        r.element      = x;
        r.last_element = last;
        return r;
    endfunction

    function automatic item_req_t random_req();
        if ($urandom_range(0, 99) < 15)
            return load_req(IDX_W'($urandom), pick_word(), pick_word());
        return elem_req(pick_word(), $urandom_range(0, 4) == 0);
    endfunction

    task automatic push_request(input item_req_t r);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_bus.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_bus.cmd          = r.cmd;
        item_bus.coeff_index  = r.coeff_index;
        item_bus.coeff_mult   = r.coeff_mult;
        item_bus.coeff_add    = r.coeff_add;
        item_bus.element      = r.element;
        item_bus.last_element = r.last_element;
        item_bus.valid        = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        board.apply_request(r);
        requests_sent++;
        burst_left--;
    endtask

    task automatic write_modulus(input logic [VAL_W-1:0] m);
        @(negedge clk);
        cfg_bus.prime_modulus = m;
        cfg_bus.valid         = 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        board.set_modulus(m);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // drain all signatures, then let a trailing element finish
    task automatic settle();
        @(negedge clk);
        item_bus.valid = 1'b0;
        burst_left     = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        push_request(load_req(3'd0, '0, '0));
        push_request(load_req(3'd1, INT_MAX, INT_MAX));
        push_request(load_req(3'd2, 31'd1, '0));
        push_request(load_req(3'd3, INT_MAX - 1, INT_MAX - 1));
        push_request(load_req(3'd4, 31'h5555_5555, 31'h2AAA_AAAA));
        push_request(load_req(3'd5, 31'h2AAA_AAAA, 31'h5555_5555));
        push_request(load_req(3'd6, VAL_W'($urandom), '0));
        push_request(load_req(3'd7, '0, VAL_W'($urandom)));
        push_request(elem_req('0, 1'b0));
        push_request(elem_req(INT_MAX, 1'b0));
        push_request(elem_req(31'd1, 1'b1));
        push_request(elem_req(INT_MAX, 1'b1));
        push_request(load_req(3'd3, VAL_W'($urandom), VAL_W'($urandom)));
        push_request(elem_req('0, 1'b1));
        repeat (3) push_request(elem_req(VAL_W'($urandom), 1'b0));
        push_request(elem_req(VAL_W'($urandom), 1'b1));
    endtask

    // receiver: random stall patterns, one long hold-off
    initial
    begin
        int       span;
        int       mode;
        bit [1:0] tick;
        span = 0;
        mode = 0;
        tick = '0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && requests_sent >= HOLD_AT)
            begin
                result_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 200);
            end
            span--;
            tick++;
            case (mode)
                0: result_bus.ready = 1'b1;
                1: result_bus.ready = ($urandom_range(0, 3) != 0);
                2: result_bus.ready = ($urandom_range(0, 3) == 0);
                default: result_bus.ready = tick[1];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            board.check_entry({result_bus.hash_index, result_bus.min_value,
                               result_bus.last_of_signature});
    end

    initial
    begin
        logic [VAL_W-1:0] moduli [8];
        int               counts [8];
        board = new();
        moduli = '{31'd0, 31'd1, 31'd2, 31'd7, 31'd65521, INT_MAX - 1,
                   VAL_W'($urandom_range(3, 32'h7FFF_FFFF)), INT_MAX};
        counts = '{30, 30, 30, 40, 80, 80, 90, 80};

        rst_n                 = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.cmd          = CMD_LOAD;
        item_bus.coeff_index  = '0;
        item_bus.coeff_mult   = '0;
        item_bus.coeff_add    = '0;
        item_bus.element      = '0;
        item_bus.last_element = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.prime_modulus = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset modulus first, all coefficients loaded before any element
        run_directed();
        settle();

        for (int p = 0; p < 8; p++)
        begin
            write_modulus(moduli[p]);
            push_request(elem_req('0, 1'b0));
            push_request(elem_req(INT_MAX, 1'b1));
            repeat (counts[p]) push_request(random_req());
            push_request(elem_req(pick_word(), 1'b1));
            settle();
        end

        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
